// ===== src/eds_pkg.sv =====
// shared constants and types for the embedding distance sum block
`default_nettype none
package eds_pkg;

  localparam int COMP_W   = 16;
  localparam int DIFF_W   = COMP_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int ACC_W    = 44;
  localparam int DIST_W   = ACC_W / 2;
  localparam int REM_W    = DIST_W + 2;
  localparam int LOSS_W   = 40;
  localparam int VLEN_W   = 11;
  localparam int NCNT_W   = 16;
  localparam int MAX_VLEN = 1024;
  localparam int CIDX_W   = $clog2(MAX_VLEN);
  localparam int STEP_W   = $clog2(DIST_W);

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [VLEN_W-1:0] VLEN_RESET   = VLEN_W'(128);
  localparam logic [NCNT_W-1:0] NCNT_RESET   = NCNT_W'(1);
  localparam logic [VLEN_W-1:0] VLEN_MAX_VAL = VLEN_W'(MAX_VLEN);

  // register index, taken from the word address
  localparam logic REG_VLEN = 1'b0;
  localparam logic REG_NCNT = 1'b1;

  // finished square sum of one node, front to queue
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] sum;
  } acc_entry_t;

  // head of the queue, queue to back
  typedef struct packed {
    logic             empty;
    logic [ACC_W-1:0] sum;
  } q_status_t;

endpackage
`default_nettype wire

// ===== src/embedding_distance_sum_top.sv =====
// top level of the embedding distance sum block with its register port
`default_nettype none
// Streams pairs of signed Q4.12 embedding components, one pair per transaction
// on the push side, and sums the squared differences of each node. After
// vector_length components (0 counts as 1, anything above 1024 as 1024) the
// node's 44-bit sum goes through a four-entry queue to the back part, where a
// bit-serial square root gives the Q10.12 distance; the distance is then added
// to a saturating 40-bit loss and one result transaction shows the distance,
// the running loss and a flag on the node_count-th node, after which the loss
// and the node count start again from zero. Components are taken at one per
// cycle while full is low; the square root unit limits the node rate for short
// vectors. Registers: vector_length at byte address 0, node_count at 4;
// write them only while no node is in progress.
module embedding_distance_sum_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [eds_pkg::COMP_W-1:0]    original_component_i,
  input  wire logic [eds_pkg::COMP_W-1:0]    fair_component_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [eds_pkg::DIST_W-1:0]         node_distance_o,
  output logic [eds_pkg::LOSS_W-1:0]         loss_total_o,
  output logic                               last_node_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [eds_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [eds_pkg::DATA_W-1:0]    pwdata,
  output logic [eds_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [eds_pkg::VLEN_W-1:0] vlen_q;
  logic [eds_pkg::NCNT_W-1:0] ncnt_q;
  logic                       wr_en;
  logic                       reg_sel;
  logic                       q_pop;
  eds_pkg::acc_entry_t        entry;
  eds_pkg::q_status_t         q_stat;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= eds_pkg::VLEN_RESET;
      ncnt_q <= eds_pkg::NCNT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        eds_pkg::REG_VLEN: vlen_q <= pwdata[eds_pkg::VLEN_W-1:0];
        eds_pkg::REG_NCNT: ncnt_q <= pwdata[eds_pkg::NCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      eds_pkg::REG_VLEN: prdata = eds_pkg::DATA_W'(vlen_q);
      eds_pkg::REG_NCNT: prdata = eds_pkg::DATA_W'(ncnt_q);
      default:           prdata = '0;
    endcase
  end

  eds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .orig_i      (original_component_i),
    .fair_i      (fair_component_i),
    .vlen_i      (vlen_q),
    .slot_free_i (q_pop),
    .entry_o     (entry)
  );

  eds_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (entry),
    .pop_i    (q_pop),
    .status_o (q_stat)
  );

  eds_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_i     (q_stat),
    .q_pop_o (q_pop),
    .ncnt_i  (ncnt_q),
    .pop_i   (pop),
    .empty_o (empty),
    .dist_o  (node_distance_o),
    .loss_o  (loss_total_o),
    .last_o  (last_node_o)
  );

endmodule
`default_nettype wire

// ===== src/eds_front.sv =====
// front part: takes components, squares differences and sums them per node
`default_nettype none
module eds_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [eds_pkg::COMP_W-1:0]   orig_i,
  input  wire logic [eds_pkg::COMP_W-1:0]   fair_i,
  input  wire logic [eds_pkg::VLEN_W-1:0]   vlen_i,
  input  wire logic                         slot_free_i,
  output eds_pkg::acc_entry_t               entry_o
);

  logic [eds_pkg::VLEN_W-1:0]        len_eff;
  logic                              take;
  logic                              last_comp;
  logic [eds_pkg::CIDX_W-1:0]        cidx_q, cidx_d;
  logic                              s1_vld_q, s1_end_q;
  logic signed [eds_pkg::DIFF_W-1:0] s1_diff_q;
  logic signed [eds_pkg::DIFF_W-1:0] diff;
  logic                              s2_vld_q, s2_end_q;
  logic [eds_pkg::SQ_W-1:0]          s2_sq_q;
  logic signed [eds_pkg::SQ_W-1:0]   prod;
  logic [eds_pkg::ACC_W-1:0]         acc_q, acc_d;
  logic [eds_pkg::ACC_W:0]           acc_sum;
  logic [eds_pkg::ACC_W-1:0]         acc_sat;
  logic [eds_pkg::QCNT_W-1:0]        pend_q, pend_d;
  logic                              pend_inc;

  always_comb begin
    len_eff = vlen_i;
    if (vlen_i == '0) begin
      len_eff = eds_pkg::VLEN_W'(1);
    end else if (vlen_i > eds_pkg::VLEN_MAX_VAL) begin
      len_eff = eds_pkg::VLEN_MAX_VAL;
    end
  end

  assign take      = push_i & ~full_o;
  assign last_comp = (eds_pkg::VLEN_W'(cidx_q) + eds_pkg::VLEN_W'(1)) >= len_eff;
  assign cidx_d    = last_comp ? '0 : cidx_q + eds_pkg::CIDX_W'(1);

  // every node end in flight holds a queue slot until the back part takes it
  assign pend_inc = take & last_comp;
  assign full_o   = (pend_q == eds_pkg::QCNT_W'(eds_pkg::QDEPTH));

  always_comb begin
    pend_d = pend_q;
    if (pend_inc && !slot_free_i) begin
      pend_d = pend_q + eds_pkg::QCNT_W'(1);
    end else if (!pend_inc && slot_free_i) begin
      pend_d = pend_q - eds_pkg::QCNT_W'(1);
    end
  end

  assign diff = $signed({orig_i[eds_pkg::COMP_W-1], orig_i})
              - $signed({fair_i[eds_pkg::COMP_W-1], fair_i});
  assign prod = s1_diff_q * s1_diff_q;

  assign acc_sum = {1'b0, acc_q} + (eds_pkg::ACC_W + 1)'(s2_sq_q);
  assign acc_sat = acc_sum[eds_pkg::ACC_W] ? '1 : acc_sum[eds_pkg::ACC_W-1:0];

  always_comb begin
    acc_d = acc_q;
    if (s2_vld_q) begin
      acc_d = s2_end_q ? '0 : acc_sat;
    end
  end

  assign entry_o.valid = s2_vld_q & s2_end_q;
  assign entry_o.sum   = acc_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cidx_q   <= '0;
      pend_q   <= '0;
      s1_vld_q <= 1'b0;
      s1_end_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s2_end_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      if (take) begin
        cidx_q <= cidx_d;
      end
      pend_q   <= pend_d;
      s1_vld_q <= take;
      s1_end_q <= last_comp;
      s2_vld_q <= s1_vld_q;
      s2_end_q <= s1_end_q;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_diff_q <= diff;
    end
    if (s1_vld_q) begin
      s2_sq_q <= prod;
    end
  end

endmodule
`default_nettype wire

// ===== src/eds_queue.sv =====
// short queue of finished square sums between front and back
`default_nettype none
module eds_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire eds_pkg::acc_entry_t entry_i,
  input  wire logic                pop_i,
  output eds_pkg::q_status_t       status_o
);

  logic [eds_pkg::ACC_W-1:0]  mem_q [eds_pkg::QDEPTH];
  logic [eds_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [eds_pkg::QCNT_W-1:0] cnt_q;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.sum   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (entry_i.valid) begin
        wr_ptr_q <= wr_ptr_q + eds_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + eds_pkg::QPTR_W'(1);
      end
      if (entry_i.valid && !pop_i) begin
        cnt_q <= cnt_q + eds_pkg::QCNT_W'(1);
      end else if (!entry_i.valid && pop_i) begin
        cnt_q <= cnt_q - eds_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_i.valid) begin
      mem_q[wr_ptr_q] <= entry_i.sum;
    end
  end

endmodule
`default_nettype wire

// ===== src/eds_back.sv =====
// back part: bit-serial square root, saturating loss sum and result register
`default_nettype none
module eds_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire eds_pkg::q_status_t          q_i,
  output logic                             q_pop_o,
  input  wire logic [eds_pkg::NCNT_W-1:0]  ncnt_i,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [eds_pkg::DIST_W-1:0]       dist_o,
  output logic [eds_pkg::LOSS_W-1:0]       loss_o,
  output logic                             last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROOT = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [eds_pkg::ACC_W-1:0]   x_q, x_d;
  logic [eds_pkg::REM_W-1:0]   rem_q, rem_d;
  logic [eds_pkg::DIST_W-1:0]  root_q, root_d;
  logic [eds_pkg::STEP_W-1:0]  step_q, step_d;
  logic [eds_pkg::REM_W+1:0]   rem_sh;
  logic [eds_pkg::REM_W+1:0]   trial;
  logic [eds_pkg::REM_W+1:0]   rem_sub;

  logic                        out_vld_q;
  logic                        out_take;
  logic                        load;
  logic [eds_pkg::NCNT_W-1:0]  node_q;
  logic [eds_pkg::LOSS_W-1:0]  run_q;
  logic [eds_pkg::NCNT_W-1:0]  cnt_eff;
  logic [eds_pkg::LOSS_W:0]    loss_sum;
  logic [eds_pkg::LOSS_W-1:0]  loss_sat;
  logic                        is_last;

  // one result bit per cycle, two radicand bits shifted in per step
  assign rem_sh  = {rem_q, x_q[eds_pkg::ACC_W-1 -: 2]};
  assign trial   = (eds_pkg::REM_W + 2)'({root_q, 2'b01});
  assign rem_sub = rem_sh - trial;

  assign out_take = pop_i & out_vld_q;
  assign load     = (state_q == S_DONE) & (~out_vld_q | out_take);

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    rem_d   = rem_q;
    root_d  = root_q;
    step_d  = step_q;
    q_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_i.empty) begin
          q_pop_o = 1'b1;
          x_d     = q_i.sum;
          rem_d   = '0;
          root_d  = '0;
          step_d  = eds_pkg::STEP_W'(eds_pkg::DIST_W - 1);
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        x_d = x_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sub[eds_pkg::REM_W-1:0];
          root_d = {root_q[eds_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[eds_pkg::REM_W-1:0];
          root_d = {root_q[eds_pkg::DIST_W-2:0], 1'b0};
        end
        step_d = step_q - eds_pkg::STEP_W'(1);
        if (step_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cnt_eff  = (ncnt_i == '0) ? eds_pkg::NCNT_W'(1) : ncnt_i;
  assign is_last  = ({1'b0, node_q} + (eds_pkg::NCNT_W + 1)'(1)) >= {1'b0, cnt_eff};
  assign loss_sum = {1'b0, run_q} + (eds_pkg::LOSS_W + 1)'(root_q);
  assign loss_sat = loss_sum[eds_pkg::LOSS_W] ? '1 : loss_sum[eds_pkg::LOSS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
      node_q    <= '0;
      run_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
      if (load) begin
        // a pass closes on its last node and the next one starts fresh
        if (is_last) begin
          node_q <= '0;
          run_q  <= '0;
        end else begin
          node_q <= node_q + eds_pkg::NCNT_W'(1);
          run_q  <= loss_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (load) begin
      dist_o <= root_q;
      loss_o <= loss_sat;
      last_o <= is_last;
    end
  end

  assign empty_o = ~out_vld_q;

endmodule
`default_nettype wire

// ===== src/eds_checker.sv =====
// port-level checker for the embedding distance sum block and its bind
`default_nettype none
module eds_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire logic [eds_pkg::DIST_W-1:0] node_distance_o,
  input wire logic [eds_pkg::LOSS_W-1:0] loss_total_o,
  input wire logic                       last_node_o,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [eds_pkg::ADDR_W-1:0] paddr,
  input wire logic [eds_pkg::DATA_W-1:0] pwdata,
  input wire logic [eds_pkg::DATA_W-1:0] prdata
);

  // a waiting result stays until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped before pop");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(node_distance_o) && $stable(loss_total_o)
                       && $stable(last_node_o))
    else $error("result changed while waiting");

  // the running loss includes the node just shown
  a_loss_covers_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> loss_total_o >= eds_pkg::LOSS_W'(node_distance_o))
    else $error("loss below node distance");

  a_vlen_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
      |-> prdata == eds_pkg::DATA_W'($past(pwdata[eds_pkg::VLEN_W-1:0])))
    else $error("vector length readback mismatch");

  a_ncnt_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[2]) ##1 paddr[2]
      |-> prdata == eds_pkg::DATA_W'($past(pwdata[eds_pkg::NCNT_W-1:0])))
    else $error("node count readback mismatch");

endmodule

bind embedding_distance_sum_top eds_checker u_eds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .node_distance_o (node_distance_o),
  .loss_total_o    (loss_total_o),
  .last_node_o     (last_node_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the embedding distance sum top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eds_pkg::*;

  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          RANDOM_ITEMS  = 460;
  localparam logic [63:0] SUM_MAX       = (64'd1 << ACC_W) - 64'd1;
  localparam logic [63:0] LOSS_MAX      = (64'd1 << LOSS_W) - 64'd1;
  localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};

  typedef struct packed {
    logic [COMP_W-1:0] orig;
    logic [COMP_W-1:0] fair;
  } comp_pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] root;
    logic [LOSS_W-1:0] loss;
    logic              last;
  } node_result_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                push     = 1'b0;
  logic                pop      = 1'b0;
  logic [COMP_W-1:0]   orig_drv = '0;
  logic [COMP_W-1:0]   fair_drv = '0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [DATA_W-1:0]   pwdata   = '0;
  logic                full;
  logic                empty;
  logic [DIST_W-1:0]   node_distance;
  logic [LOSS_W-1:0]   loss_total;
  logic                last_node;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  embedding_distance_sum_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .original_component_i (orig_drv),
    .fair_component_i     (fair_drv),
    .empty                (empty),
    .pop                  (pop),
    .node_distance_o      (node_distance),
    .loss_total_o         (loss_total),
    .last_node_o          (last_node),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state and configuration
  logic [VLEN_W-1:0] vector_len_cfg = VLEN_RESET;
  logic [NCNT_W-1:0] node_count_cfg = NCNT_RESET;
  int unsigned       comp_idx       = 0;
  logic [63:0]       square_sum     = '0;
  logic [NCNT_W-1:0] node_idx       = '0;
  logic [63:0]       loss_sum       = '0;

  comp_pair_t   queued_pairs[$];
  node_result_t awaited_results[$];
  int unsigned  mismatch_count = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 20) $display("%0t ERROR %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // floor square root, one result bit per step from the top
  function automatic logic [DIST_W-1:0] floor_root(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  task automatic accumulate_component(input comp_pair_t p);
    int unsigned  len;
    int unsigned  cnt;
    longint       diff;
    logic [63:0]  sq;
    node_result_t r;
    len = (vector_len_cfg == 0) ? 1 : (vector_len_cfg > MAX_VLEN) ? MAX_VLEN : vector_len_cfg;
    cnt = (node_count_cfg == 0) ? 1 : node_count_cfg;
    diff = longint'($signed(p.orig)) - longint'($signed(p.fair));
    if (diff < 0) diff = -diff;
    sq = diff * diff;
    square_sum = (sq > SUM_MAX - square_sum) ? SUM_MAX : square_sum + sq;
    if (comp_idx + 1 < len) begin
      comp_idx++;
      return;
    end
    comp_idx = 0;
    r.root = floor_root(square_sum);
    square_sum = '0;
    loss_sum = (r.root > LOSS_MAX - loss_sum) ? LOSS_MAX : loss_sum + r.root;
    r.loss = loss_sum[LOSS_W-1:0];
    r.last = (node_idx + 1 >= cnt);
    if (r.last) begin
      node_idx = '0;
      loss_sum = '0;
    end else begin
      node_idx = node_idx + 1'b1;
    end
    awaited_results.push_back(r);
  endtask

  // component driver
  int unsigned send_gap   = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk_i) begin : component_driver
    comp_pair_t nxt;
    if (rst_ni) begin
      if (push && !full) accumulate_component({orig_drv, fair_drv});
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (queued_pairs.size() > 0) begin
          nxt = queued_pairs.pop_front();
          orig_drv <= nxt.orig;
          fair_drv <= nxt.fair;
          push     <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          send_gap = draw_wait(send_burst);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int unsigned recv_stall = 0;
  bit          recv_burst = 1'b0;

  always @(posedge clk_i) begin : result_monitor
    node_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transaction with no node awaited");
        end else begin
          want = awaited_results.pop_front();
          if (node_distance !== want.root)
            report_mismatch($sformatf("node_distance %0d, want %0d", node_distance, want.root));
          if (loss_total !== want.loss)
            report_mismatch($sformatf("loss_total %0d, want %0d", loss_total, want.loss));
          if (last_node !== want.last)
            report_mismatch($sformatf("last_node %0b, want %0b", last_node, want.last));
        end
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        recv_stall = draw_wait(recv_burst);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      pop <= (recv_stall == 0);
    end
  end

  // ends the run when nothing moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("embedding_distance_sum_top: mismatch");
          $finish;
        end
      end
    end
  end

  // register write followed by a readback
  task automatic write_config(input logic reg_idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] kept;
    kept = (reg_idx == REG_VLEN) ? DATA_W'(value[VLEN_W-1:0]) : DATA_W'(value[NCNT_W-1:0]);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_VLEN) vector_len_cfg = value[VLEN_W-1:0];
    else node_count_cfg = value[NCNT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept)
      report_mismatch($sformatf("readback at %0d: %h, want %h", {reg_idx, 2'b00}, prdata, kept));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (queued_pairs.size() > 0 || push || awaited_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // unused upper data bits carry noise that the register must drop
  task automatic set_sizes(input logic [VLEN_W-1:0] vl, input logic [NCNT_W-1:0] nc);
    logic [DATA_W-1:0] noise;
    wait_idle();
    noise = $urandom;
    write_config(REG_VLEN, {noise[DATA_W-1:VLEN_W], vl});
    noise = $urandom;
    write_config(REG_NCNT, {noise[DATA_W-1:NCNT_W], nc});
  endtask

  task automatic add_pair(input logic [COMP_W-1:0] orig, input logic [COMP_W-1:0] fair);
    queued_pairs.push_back({orig, fair});
  endtask

  function automatic logic [COMP_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return COMP_MIN;
      1:       return COMP_MAX;
      2:       return '0;
      3:       return '1;
      4:       return COMP_W'(1);
      default: return COMP_MIN + 1'b1;
    endcase
  endfunction

  function automatic comp_pair_t random_pair();
    comp_pair_t p;
    case ($urandom_range(0, 7))
      0, 1: begin
        p.orig = corner_value();
        p.fair = corner_value();
      end
      2, 3: begin
        p.orig = COMP_W'($urandom);
        p.fair = p.orig + COMP_W'($urandom_range(0, 64)) - COMP_W'(32);
      end
      default: begin
        p.orig = COMP_W'($urandom);
        p.fair = COMP_W'($urandom);
      end
    endcase
    return p;
  endfunction

  initial begin : stimulus
    int unsigned       random_items;
    int unsigned       len_eff;
    int unsigned       nodes;
    logic [VLEN_W-1:0] vl;
    logic [NCNT_W-1:0] nc;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one node at the reset sizes
    repeat (VLEN_RESET) queued_pairs.push_back(random_pair());

    // one component per node, extremes of the difference
    set_sizes(1, 3);
    add_pair(COMP_MAX, COMP_MIN);
    add_pair(COMP_MIN, COMP_MAX);
    add_pair('0, '0);
    add_pair(COMP_MIN, COMP_MIN);
    add_pair(COMP_MAX, COMP_MAX);
    add_pair(COMP_W'(1), '0);
    add_pair('0, COMP_W'(1));
    add_pair('1, COMP_W'(1));
    // zero length and zero count
    set_sizes(0, 0);
    add_pair(16'h1234, 16'hedcc);
    add_pair(COMP_MIN, COMP_MAX);
    // count lowered below the nodes already done in this pass
    set_sizes(1, 5);
    add_pair(16'h0100, 16'hff00);
    add_pair(16'h0800, 16'h0000);
    add_pair(COMP_MAX, '0);
    set_sizes(1, 2);
    add_pair(16'h4000, 16'hc000);
    add_pair(16'h0010, 16'h0020);
    // largest square in every component of a short node
    set_sizes(3, 1);
    repeat (3) add_pair(COMP_MAX, COMP_MIN);

    random_items = 0;
    for (int ph = 0; random_items < RANDOM_ITEMS; ph++) begin
      case ($urandom_range(0, 9))
        0:       vl = 0;
        1, 2:    vl = 1;
        3, 4:    vl = VLEN_W'($urandom_range(2, 4));
        5, 6, 7: vl = VLEN_W'($urandom_range(5, 24));
        default: vl = VLEN_W'($urandom_range(25, 64));
      endcase
      case ($urandom_range(0, 7))
        0:       nc = 0;
        1:       nc = 1;
        2:       nc = '1;
        default: nc = NCNT_W'($urandom_range(2, 6));
      endcase
      if (ph == 0) nc = '1;
      len_eff = (vl == 0) ? 1 : vl;
      nodes = $urandom_range(40, 120) / len_eff;
      if (nodes == 0) nodes = 1;
      set_sizes(vl, nc);
      repeat (nodes * len_eff) begin
        queued_pairs.push_back(random_pair());
        random_items++;
      end
    end

    // length field at all ones, clamped to the longest vector
    set_sizes('1, 1);
    repeat (MAX_VLEN) begin
      if ($urandom_range(0, 3) == 0) queued_pairs.push_back(random_pair());
      else if ($urandom_range(0, 1) == 0) add_pair(COMP_MAX, COMP_MIN);
      else add_pair(COMP_MIN, COMP_MAX);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("embedding_distance_sum_top: match");
    end else begin
      $display("embedding_distance_sum_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== embedding_distance_sum_top.f =====
src/eds_pkg.sv
src/eds_front.sv
src/eds_queue.sv
src/eds_back.sv
src/embedding_distance_sum_top.sv
src/eds_checker.sv
tb/tb.sv
